@@ sv/tlc_pkg.sv @@
// shared types and constants for the task lifecycle checker
package tlc_pkg;

   // result status codes
   localparam logic [2:0] STATUS_OK         = 3'd0;
   localparam logic [2:0] STATUS_SEQ_GAP    = 3'd1;
   localparam logic [2:0] STATUS_ILLEGAL    = 3'd2;
   localparam logic [2:0] STATUS_UNFINISHED = 3'd3;
   localparam logic [2:0] STATUS_HALTED     = 3'd4;

   // task lifecycle state codes
   localparam logic [2:0] TS_NONE     = 3'd0;
   localparam logic [2:0] TS_FINISHED = 3'd4;

   // input function codes
   localparam logic FUNC_EVENT = 1'b0;
   localparam logic FUNC_END   = 1'b1;

   // sequence counter limit
   localparam logic [31:0] SEQ_MAX = 32'hFFFF_FFFF;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EVAL,
      ST_SCAN,
      ST_OUT
   } tlc_state_type;

   typedef enum logic [1:0] {
      RES_EVENT,
      RES_HALT,
      RES_SCAN_HIT,
      RES_SCAN_NONE
   } tlc_res_sel_type;

   // controller to datapath
   typedef struct packed {
      logic            accept;
      logic            scan;
      logic            load_res;
      tlc_res_sel_type res_sel;
      logic            clear_all;
      logic            out_load;
   } tlc_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic func;
      logic halted;
      logic scan_hit;
      logic scan_last;
      logic out_free;
   } tlc_status_type;

endpackage

@@ sv/tlc_ctrl.sv @@
// controller state machine for the task lifecycle checker
module tlc_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  tlc_pkg::tlc_status_type st,
   output tlc_pkg::tlc_cmd_type    cmd
);
   import tlc_pkg::*;

   tlc_state_type state_ff;
   tlc_state_type state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in      = state_ff;
      cmd           = '0;
      cmd.res_sel   = RES_EVENT;
      req_stall     = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = ST_EVAL;
            end
         end
         ST_EVAL: begin
            if (st.func == FUNC_EVENT) begin
               cmd.load_res = 1'b1;
               cmd.res_sel  = RES_EVENT;
               state_in     = ST_OUT;
            end else if (st.halted) begin
               cmd.load_res  = 1'b1;
               cmd.res_sel   = RES_HALT;
               cmd.clear_all = 1'b1;
               state_in      = ST_OUT;
            end else begin
               cmd.scan = 1'b1;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (st.scan_hit) begin
               cmd.load_res  = 1'b1;
               cmd.res_sel   = RES_SCAN_HIT;
               cmd.clear_all = 1'b1;
               state_in      = ST_OUT;
            end else if (st.scan_last) begin
               cmd.load_res  = 1'b1;
               cmd.res_sel   = RES_SCAN_NONE;
               cmd.clear_all = 1'b1;
               state_in      = ST_OUT;
            end else begin
               cmd.scan = 1'b1;
            end
         end
         ST_OUT: begin
            if (st.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // a table scan only runs for an end of trace that found no earlier error
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (st.func == FUNC_END) && !st.halted)
      else $error("scan running for an event or while halted");

   // the output register is only loaded once it can take a word
   assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> st.out_free)
      else $error("output loaded while occupied");

endmodule

@@ sv/tlc_datapath.sv @@
// datapath: task state table, sequence counter, result and output registers
module tlc_datapath #(
   parameter int TASKS = 256
) (
   input  logic                   clock,
   input  logic                   reset,
   input  tlc_pkg::tlc_cmd_type    cmd,
   output tlc_pkg::tlc_status_type st,
   input  logic                   req_func,
   input  logic [1:0]             req_event_kind,
   input  logic [7:0]             req_task_id,
   input  logic [31:0]            req_seq_number,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [2:0]             rsp_status,
   output logic [7:0]             rsp_bad_task,
   output logic [31:0]            rsp_bad_seq,
   output logic [2:0]             rsp_found_state,
   output logic [31:0]            rsp_expected_seq
);
   import tlc_pkg::*;

   // only ids below 256 can reach the table
   localparam int DEPTH = (TASKS < 256) ? TASKS : 256;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam logic [AW:0] DEPTH_W = (AW + 1)'(DEPTH);
   localparam logic [AW:0] LAST_W  = (AW + 1)'(DEPTH - 1);
   localparam logic [AW:0] ONE_W   = (AW + 1)'(1);
   localparam logic [16:0] TASKS_W = 17'(TASKS);

   // latched input word
   logic        func_ff;
   logic [1:0]  kind_ff;
   logic [7:0]  task_ff;
   logic [31:0] seq_ff;

   // table storage and valid bits
   logic [2:0]       mem [DEPTH];
   logic [DEPTH-1:0] valid_ff;
   logic [2:0]       mem_rd_ff;
   logic             rd_valid_ff;
   logic [AW-1:0]    rd_addr;
   logic             rd_en;
   logic             wr_en;
   logic [2:0]       rd_state;

   // scan bookkeeping
   logic [AW:0] scan_idx_ff;
   logic [AW:0] rd_idx_ff;
   logic        rd_live_ff;
   logic        open_entry;

   // counter and error latch
   logic [31:0] next_seq_ff;
   logic        halted_ff;

   // event checks
   logic        seq_bad;
   logic        task_out;
   logic        trans_ok;
   logic        event_ok;
   logic [31:0] last_seq;

   // pending result
   logic [2:0]  res_status_in, res_status_ff;
   logic [7:0]  res_task_in, res_task_ff;
   logic [31:0] res_seq_in, res_seq_ff;
   logic [2:0]  res_found_in, res_found_ff;
   logic [31:0] res_exp_in, res_exp_ff;

   // output register
   logic        rsp_valid_ff;
   logic [2:0]  rsp_status_ff;
   logic [7:0]  rsp_bad_task_ff;
   logic [31:0] rsp_bad_seq_ff;
   logic [2:0]  rsp_found_ff;
   logic [31:0] rsp_exp_ff;
   logic        out_free;

   // input word latch
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         func_ff <= req_func;
         kind_ff <= req_event_kind;
         task_ff <= req_task_id;
         seq_ff  <= req_seq_number;
      end
   end

   // table read address: incoming task or scan pointer
   assign rd_addr = cmd.scan ? scan_idx_ff[AW-1:0] : req_task_id[AW-1:0];
   assign rd_en   = cmd.accept || cmd.scan;

   // table memory, registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[task_ff[AW-1:0]] <= {1'b0, kind_ff} + 3'd1;
      end
      if (rd_en) begin
         mem_rd_ff   <= mem[rd_addr];
         rd_valid_ff <= valid_ff[rd_addr];
      end
   end

   // valid bits, cleared at reset and at end of trace
   always_ff @(posedge clock) begin
      if (reset || cmd.clear_all) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[task_ff[AW-1:0]] <= 1'b1;
      end
   end

   assign rd_state = rd_valid_ff ? mem_rd_ff : TS_NONE;

   // scan pointer and read tracking
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_live_ff <= 1'b0;
      end else if (rd_en) begin
         rd_live_ff <= cmd.scan && (scan_idx_ff < DEPTH_W);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         scan_idx_ff <= '0;
      end else if (cmd.scan) begin
         scan_idx_ff <= scan_idx_ff + ONE_W;
      end
      if (rd_en) begin
         rd_idx_ff <= scan_idx_ff;
      end
   end

   assign open_entry   = (rd_state != TS_NONE) && (rd_state != TS_FINISHED);
   assign st.scan_hit  = rd_live_ff && open_entry;
   assign st.scan_last = rd_live_ff && (rd_idx_ff == LAST_W);
   assign st.func      = func_ff;
   assign st.halted    = halted_ff;
   assign st.out_free  = out_free;

   // event checks against counter and table
   assign seq_bad  = (seq_ff != next_seq_ff) || (next_seq_ff == SEQ_MAX);
   assign task_out = ({9'd0, task_ff} >= TASKS_W);
   assign trans_ok = (rd_state == {1'b0, kind_ff});
   assign event_ok = !halted_ff && !seq_bad && !task_out && trans_ok;
   assign wr_en    = cmd.load_res && (cmd.res_sel == RES_EVENT) && event_ok;
   assign last_seq = (next_seq_ff != 32'd0) ? (next_seq_ff - 32'd1) : 32'd0;

   // result selection
   always_comb begin
      res_status_in = STATUS_HALTED;
      res_task_in   = 8'd0;
      res_seq_in    = 32'd0;
      res_found_in  = TS_NONE;
      res_exp_in    = 32'd0;
      case (cmd.res_sel)
         RES_EVENT: begin
            if (halted_ff) begin
               res_status_in = STATUS_HALTED;
            end else if (seq_bad) begin
               res_status_in = STATUS_SEQ_GAP;
               res_task_in   = task_ff;
               res_seq_in    = seq_ff;
               res_exp_in    = next_seq_ff;
            end else if (task_out) begin
               res_status_in = STATUS_ILLEGAL;
               res_task_in   = task_ff;
               res_seq_in    = seq_ff;
               res_exp_in    = next_seq_ff;
            end else if (!trans_ok) begin
               res_status_in = STATUS_ILLEGAL;
               res_task_in   = task_ff;
               res_seq_in    = seq_ff;
               res_found_in  = rd_state;
               res_exp_in    = next_seq_ff;
            end else begin
               res_status_in = STATUS_OK;
               res_found_in  = rd_state;
               res_exp_in    = next_seq_ff;
            end
         end
         RES_HALT: begin
            res_status_in = STATUS_HALTED;
         end
         RES_SCAN_HIT: begin
            res_status_in = STATUS_UNFINISHED;
            res_task_in   = 8'(rd_idx_ff);
            res_seq_in    = last_seq;
            res_found_in  = rd_state;
            res_exp_in    = next_seq_ff;
         end
         RES_SCAN_NONE: begin
            res_status_in = STATUS_OK;
            res_exp_in    = next_seq_ff;
         end
         default: begin
            res_status_in = STATUS_HALTED;
         end
      endcase
   end

   // pending result register
   always_ff @(posedge clock) begin
      if (cmd.load_res) begin
         res_status_ff <= res_status_in;
         res_task_ff   <= res_task_in;
         res_seq_ff    <= res_seq_in;
         res_found_ff  <= res_found_in;
         res_exp_ff    <= res_exp_in;
      end
   end

   // sequence counter and error latch
   always_ff @(posedge clock) begin
      if (reset || cmd.clear_all) begin
         next_seq_ff <= 32'd0;
         halted_ff   <= 1'b0;
      end else if (cmd.load_res && (cmd.res_sel == RES_EVENT)) begin
         if (event_ok) begin
            next_seq_ff <= next_seq_ff + 32'd1;
         end else begin
            halted_ff <= 1'b1;
         end
      end
   end

   // output word register
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_status_ff   <= res_status_ff;
         rsp_bad_task_ff <= res_task_ff;
         rsp_bad_seq_ff  <= res_seq_ff;
         rsp_found_ff    <= res_found_ff;
         rsp_exp_ff      <= res_exp_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_bad_task     = rsp_bad_task_ff;
   assign rsp_bad_seq      = rsp_bad_seq_ff;
   assign rsp_found_state  = rsp_found_ff;
   assign rsp_expected_seq = rsp_exp_ff;

   // a halted checker never changes the table
   assert property (@(posedge clock) disable iff (reset)
      halted_ff |-> !wr_en)
      else $error("table written while halted");

   // end of trace leaves a fresh counter and no latched error
   assert property (@(posedge clock) disable iff (reset)
      cmd.clear_all |=> (next_seq_ff == 32'd0) && !halted_ff && (valid_ff == '0))
      else $error("state not cleared after end of trace");

   // a table write always comes with a counter step
   assert property (@(posedge clock) disable iff (reset)
      wr_en |=> (next_seq_ff == $past(next_seq_ff) + 32'd1))
      else $error("counter did not advance with table update");

endmodule

@@ sv/task_lifecycle_checker_top.sv @@
// event words: one word at a time; the next is accepted once the last result has entered the output register
// end of trace: scans up to min(TASKS,256) table entries, 1 entry a cycle, stopping at
//   the first open entry, then result; no scan once an error is latched; single table read port
// a result waiting in the output register does not block acceptance of the next word
// reset clears the table valid bits, counter and error latch at once
module task_lifecycle_checker_top #(
   parameter int TASKS = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_func,
   input  logic [1:0]  req_event_kind,
   input  logic [7:0]  req_task_id,
   input  logic [31:0] req_seq_number,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_status,
   output logic [7:0]  rsp_bad_task,
   output logic [31:0] rsp_bad_seq,
   output logic [2:0]  rsp_found_state,
   output logic [31:0] rsp_expected_seq
);
   import tlc_pkg::*;

   tlc_cmd_type    cmd;
   tlc_status_type st;

   // controller
   tlc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .st        (st),
      .cmd       (cmd)
   );

   // datapath
   tlc_datapath #(
      .TASKS (TASKS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .st               (st),
      .req_func         (req_func),
      .req_event_kind   (req_event_kind),
      .req_task_id      (req_task_id),
      .req_seq_number   (req_seq_number),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_bad_task     (rsp_bad_task),
      .rsp_bad_seq      (rsp_bad_seq),
      .rsp_found_state  (rsp_found_state),
      .rsp_expected_seq (rsp_expected_seq)
   );

endmodule

@@ dv/task_lifecycle_checker_top_tb.sv @@
// testbench for the task lifecycle checker: directed table, random traces, scoreboard
`timescale 1ns / 1ps

module task_lifecycle_checker_top_tb;
   import tlc_pkg::*;

   localparam int HALF_PERIOD  = 10;
   localparam int RESET_CYCLES = 9;
   localparam int TASK_COUNT   = 256;
   localparam int PHASE_WORDS  = 415;
   localparam int DRAIN_CYCLES = 300;
   localparam int HANG_LIMIT   = 4000;

   // event kinds
   localparam logic [1:0] EV_ENQUEUED = 2'd0;
   localparam logic [1:0] EV_DEQUEUED = 2'd1;
   localparam logic [1:0] EV_STARTED  = 2'd2;
   localparam logic [1:0] EV_FINISHED = 2'd3;

   // lifecycle states between none and finished
   localparam logic [2:0] TS_ENQUEUED = 3'd1;
   localparam logic [2:0] TS_DEQUEUED = 3'd2;

   // how a table row is checked
   localparam bit CHECK_PREDICT = 1'b0;
   localparam bit CHECK_TYPED   = 1'b1;

   typedef struct packed {
      logic [2:0]  status;
      logic [7:0]  bad_task;
      logic [31:0] bad_seq;
      logic [2:0]  found_state;
      logic [31:0] expected_seq;
   } check_result_type;

   typedef struct packed {
      logic             func;
      logic [1:0]       kind;
      logic [7:0]       tid;
      logic [31:0]      seq;
      bit               typed;
      check_result_type result;
   } stim_row_type;

   localparam check_result_type NO_RESULT     = '0;
   localparam check_result_type HALTED_RESULT = '{STATUS_HALTED, 8'd0, 32'd0, TS_NONE, 32'd0};

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_func = FUNC_EVENT;
   logic [1:0]  req_event_kind = EV_ENQUEUED;
   logic [7:0]  req_task_id = 8'd0;
   logic [31:0] req_seq_number = 32'd0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [2:0]  rsp_status;
   logic [7:0]  rsp_bad_task;
   logic [31:0] rsp_bad_seq;
   logic [2:0]  rsp_found_state;
   logic [31:0] rsp_expected_seq;

   // shadow of the checker state
   logic [2:0]  task_table [TASK_COUNT];
   logic [31:0] trace_seq = 32'd0;
   bit          trace_halted = 1'b0;

   check_result_type pending_results [$];
   int words_sent = 0;
   int error_count = 0;
   int hang_cycles = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;

   // directed words: reset, extremes, every kind, every status
   stim_row_type directed_rows [0:25] = '{
      '{FUNC_END,   EV_ENQUEUED, 8'd0,   32'd0,  CHECK_TYPED,
        '{STATUS_OK, 8'd0, 32'd0, TS_NONE, 32'd0}},
      '{FUNC_EVENT, EV_ENQUEUED, 8'd0,   32'd0,  CHECK_TYPED,
        '{STATUS_OK, 8'd0, 32'd0, TS_NONE, 32'd0}},
      '{FUNC_EVENT, EV_DEQUEUED, 8'd0,   32'd1,  CHECK_PREDICT, NO_RESULT},
      '{FUNC_EVENT, EV_STARTED,  8'd0,   32'd2,  CHECK_PREDICT, NO_RESULT},
      '{FUNC_EVENT, EV_FINISHED, 8'd0,   32'd3,  CHECK_PREDICT, NO_RESULT},
      '{FUNC_EVENT, EV_ENQUEUED, 8'd255, 32'd4,  CHECK_PREDICT, NO_RESULT},
      '{FUNC_EVENT, EV_DEQUEUED, 8'd255, 32'd5,  CHECK_PREDICT, NO_RESULT},
      // end of trace ignores its other fields
      '{FUNC_END,   EV_FINISHED, 8'd255, 32'hFFFF_FFFF, CHECK_TYPED,
        '{STATUS_UNFINISHED, 8'd255, 32'd5, TS_DEQUEUED, 32'd6}},
      '{FUNC_EVENT, EV_ENQUEUED, 8'h55,  32'd0,  CHECK_PREDICT, NO_RESULT},
      '{FUNC_EVENT, EV_ENQUEUED, 8'hAA,  32'd1,  CHECK_PREDICT, NO_RESULT},
      '{FUNC_EVENT, EV_STARTED,  8'hAA,  32'd2,  CHECK_TYPED,
        '{STATUS_ILLEGAL, 8'hAA, 32'd2, TS_ENQUEUED, 32'd2}},
      '{FUNC_EVENT, EV_DEQUEUED, 8'h55,  32'd2,  CHECK_TYPED, HALTED_RESULT},
      '{FUNC_END,   EV_ENQUEUED, 8'd0,   32'd0,  CHECK_TYPED, HALTED_RESULT},
      // sequence gap at the very top of the range
      '{FUNC_EVENT, EV_ENQUEUED, 8'd0,   32'hFFFF_FFFF, CHECK_TYPED,
        '{STATUS_SEQ_GAP, 8'd0, 32'hFFFF_FFFF, TS_NONE, 32'd0}},
      '{FUNC_END,   EV_STARTED,  8'd9,   32'd7,  CHECK_TYPED, HALTED_RESULT},
      // finish on a task never seen
      '{FUNC_EVENT, EV_FINISHED, 8'd7,   32'd0,  CHECK_TYPED,
        '{STATUS_ILLEGAL, 8'd7, 32'd0, TS_NONE, 32'd0}},
      '{FUNC_END,   EV_ENQUEUED, 8'd0,   32'd0,  CHECK_TYPED, HALTED_RESULT},
      '{FUNC_EVENT, EV_ENQUEUED, 8'd1,   32'd0,  CHECK_PREDICT, NO_RESULT},
      '{FUNC_EVENT, EV_DEQUEUED, 8'd1,   32'd1,  CHECK_PREDICT, NO_RESULT},
      '{FUNC_EVENT, EV_STARTED,  8'd1,   32'd2,  CHECK_PREDICT, NO_RESULT},
      '{FUNC_EVENT, EV_FINISHED, 8'd1,   32'd3,  CHECK_PREDICT, NO_RESULT},
      // all seen tasks finished
      '{FUNC_END,   EV_ENQUEUED, 8'd0,   32'd0,  CHECK_TYPED,
        '{STATUS_OK, 8'd0, 32'd0, TS_NONE, 32'd4}},
      '{FUNC_EVENT, EV_ENQUEUED, 8'd2,   32'd0,  CHECK_PREDICT, NO_RESULT},
      '{FUNC_EVENT, EV_ENQUEUED, 8'd3,   32'd2,  CHECK_TYPED,
        '{STATUS_SEQ_GAP, 8'd3, 32'd2, TS_NONE, 32'd1}},
      '{FUNC_END,   EV_ENQUEUED, 8'd0,   32'd0,  CHECK_TYPED, HALTED_RESULT},
      // empty trace
      '{FUNC_END,   EV_ENQUEUED, 8'd0,   32'd0,  CHECK_TYPED,
        '{STATUS_OK, 8'd0, 32'd0, TS_NONE, 32'd0}}
   };

   task_lifecycle_checker_top #(
      .TASKS (TASK_COUNT)
   ) uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_func         (req_func),
      .req_event_kind   (req_event_kind),
      .req_task_id      (req_task_id),
      .req_seq_number   (req_seq_number),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_bad_task     (rsp_bad_task),
      .rsp_bad_seq      (rsp_bad_seq),
      .rsp_found_state  (rsp_found_state),
      .rsp_expected_seq (rsp_expected_seq)
   );

   always #HALF_PERIOD clock = ~clock;

   initial begin
      foreach (task_table[i]) task_table[i] = TS_NONE;
   end

   // lifecycle and sequence check of one word, updates the shadow state
   function automatic check_result_type lifecycle_predict(input logic func,
                                                          input logic [1:0] kind,
                                                          input logic [7:0] tid,
                                                          input logic [31:0] seq);
      check_result_type r;
      logic [2:0] cur;
      bit hit;
      r = '0;
      hit = 1'b0;
      if (func == FUNC_END) begin
         if (trace_halted) begin
            r.status = STATUS_HALTED;
         end else begin
            r.expected_seq = trace_seq;
            // lowest task seen but not finished
            for (int i = 0; i < TASK_COUNT && !hit; i++) begin
               if (task_table[i] != TS_NONE && task_table[i] != TS_FINISHED) begin
                  hit = 1'b1;
                  r.status = STATUS_UNFINISHED;
                  r.bad_task = 8'(i);
                  r.found_state = task_table[i];
                  r.bad_seq = (trace_seq != 32'd0) ? trace_seq - 32'd1 : 32'd0;
               end
            end
         end
         foreach (task_table[i]) task_table[i] = TS_NONE;
         trace_seq = 32'd0;
         trace_halted = 1'b0;
      end else if (trace_halted) begin
         r.status = STATUS_HALTED;
      end else if (seq != trace_seq || trace_seq == SEQ_MAX) begin
         // gap, or a counter that cannot count one more
         r = '{STATUS_SEQ_GAP, tid, seq, TS_NONE, trace_seq};
         trace_halted = 1'b1;
      end else if (int'(tid) >= TASK_COUNT) begin
         r = '{STATUS_ILLEGAL, tid, seq, TS_NONE, trace_seq};
         trace_halted = 1'b1;
      end else begin
         cur = task_table[tid];
         if (cur != {1'b0, kind}) begin
            r = '{STATUS_ILLEGAL, tid, seq, cur, trace_seq};
            trace_halted = 1'b1;
         end else begin
            task_table[tid] = {1'b0, kind} + 3'd1;
            r.found_state = cur;
            r.expected_seq = trace_seq;
            trace_seq = trace_seq + 32'd1;
         end
      end
      return r;
   endfunction

   // drive one word at the falling edge, hold it until taken
   task automatic send_word(input logic func, input logic [1:0] kind,
                            input logic [7:0] tid, input logic [31:0] seq,
                            input bit typed, input check_result_type typed_result);
      check_result_type predicted;
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_func       <= func;
      req_event_kind <= kind;
      req_task_id    <= tid;
      req_seq_number <= seq;
      do @(posedge clock); while (req_stall);
      predicted = lifecycle_predict(func, kind, tid, seq);
      pending_results.push_back(typed ? typed_result : predicted);
      words_sent++;
   endtask

   // one trace: mostly legal events in a window of tasks, sometimes broken
   task automatic run_random_trace();
      logic [7:0]  base;
      logic [7:0]  tid;
      logic [1:0]  kind;
      logic [31:0] seq;
      int          trace_len;
      int          err_at;
      bit          complete;
      bit          found;
      base      = 8'($urandom_range(0, 248));
      trace_len = $urandom_range(1, 30);
      err_at    = ($urandom_range(99) < 25) ? $urandom_range(0, trace_len - 1) : -1;
      complete  = ($urandom_range(99) < 35);
      for (int n = 0; n < trace_len; n++) begin
         // occasional noise word
         if ($urandom_range(99) < 4) begin
            send_word(FUNC_EVENT, 2'($urandom), 8'($urandom), $urandom, CHECK_PREDICT,
                      NO_RESULT);
            continue;
         end
         found = 1'b0;
         tid = base;
         for (int tries = 0; tries < 16 && !found; tries++) begin
            tid = base + 8'($urandom_range(0, 7));
            found = (task_table[tid] != TS_FINISHED);
         end
         if (!found) break;
         kind = task_table[tid][1:0];
         seq  = trace_seq;
         if (n == err_at) begin
            case ($urandom_range(2))
               0: seq = $urandom;
               1: seq = ($urandom_range(1)) ? trace_seq + 32'($urandom_range(1, 2))
                                            : trace_seq - 32'd1;
               default: kind = kind + 2'($urandom_range(1, 3));
            endcase
         end
         send_word(FUNC_EVENT, kind, tid, seq, CHECK_PREDICT, NO_RESULT);
      end
      // sometimes bring every seen task of the window to finished, unless the trace halted
      if (complete) begin
         for (int t = 0; t < 8; t++) begin
            tid = base + 8'(t);
            while (!trace_halted && task_table[tid] != TS_NONE &&
                   task_table[tid] != TS_FINISHED)
               send_word(FUNC_EVENT, task_table[tid][1:0], tid, trace_seq, CHECK_PREDICT,
                         NO_RESULT);
         end
      end
      send_word(FUNC_END, 2'($urandom), 8'($urandom), $urandom, CHECK_PREDICT, NO_RESULT);
   endtask

   // result side back-pressure
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_idle_pct);
   end

   task automatic compare_field(input string name, input logic [31:0] exp_val,
                                input logic [31:0] act_val);
      if (exp_val !== act_val) begin
         $error("%s: expected %0h, got %0h", name, exp_val, act_val);
         error_count++;
      end
   endtask

   // scoreboard: each taken result against the oldest expectation
   always @(posedge clock) begin
      check_result_type exp_res;
      if (!reset && rsp_valid === 1'b1 && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            $error("result word with nothing expected, status %0d", rsp_status);
            error_count++;
         end else begin
            exp_res = pending_results.pop_front();
            compare_field("status", 32'(exp_res.status), 32'(rsp_status));
            compare_field("bad_task", 32'(exp_res.bad_task), 32'(rsp_bad_task));
            compare_field("bad_seq", exp_res.bad_seq, rsp_bad_seq);
            compare_field("found_state", 32'(exp_res.found_state), 32'(rsp_found_state));
            compare_field("expected_seq", exp_res.expected_seq, rsp_expected_seq);
         end
      end
   end

   // watchdog on cycles with no word moving on either side
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid === 1'b1 && !rsp_stall)) begin
         hang_cycles <= 0;
      end else begin
         hang_cycles <= hang_cycles + 1;
         if (hang_cycles >= HANG_LIMIT) begin
            $display("task_lifecycle_checker_top_tb: FAIL");
            $finish;
         end
      end
   end

   // stimulus sequence
   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // slow sender, heavily stalled receiver
      send_idle_pct = 28;
      recv_idle_pct = 83;
      foreach (directed_rows[i])
         send_word(directed_rows[i].func, directed_rows[i].kind, directed_rows[i].tid,
                   directed_rows[i].seq, directed_rows[i].typed, directed_rows[i].result);
      while (words_sent < PHASE_WORDS) run_random_trace();

      // mostly idle sender, light stalls
      send_idle_pct = 83;
      recv_idle_pct = 28;
      while (words_sent < 2 * PHASE_WORDS) run_random_trace();

      // full rate both sides
      send_idle_pct = 0;
      recv_idle_pct = 0;
      while (words_sent < 3 * PHASE_WORDS) run_random_trace();

      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0)
         $display("task_lifecycle_checker_top_tb: PASS");
      else
         $display("task_lifecycle_checker_top_tb: FAIL");
      $finish;
   end

endmodule

@@ filelist.f @@
sv/tlc_pkg.sv
sv/tlc_ctrl.sv
sv/tlc_datapath.sv
sv/task_lifecycle_checker_top.sv
dv/task_lifecycle_checker_top_tb.sv
